>>> rtl/core/sebfr_pkg.sv
// Package for the STX/ETX frame receiver with XOR block check.
// Holds the marker byte constants and the result record type.
// Depends on nothing; used by sebfr_deframer and the top level.
`default_nettype none

package sebfr_pkg;

   localparam logic [7:0] MARK_START = 8'h02;
   localparam logic [7:0] MARK_END   = 8'h03;

   localparam logic [5:0] MAX_PAYLOAD_RESET = 6'd20;

   typedef struct packed {
      logic       overflow;
      logic       check_fail;
      logic [5:0] frame_length;
      logic       frame_ok;
      logic [7:0] store_data;
      logic [4:0] store_index;
      logic       store_valid;
   } result_type;

endpackage

`default_nettype wire

>>> rtl/core/stx_etx_bcc_frame_receiver.sv
// Top level of the STX/ETX frame receiver with XOR block check: the input
// register, the result register and the stream handshake around them.
// Depends on sebfr_pkg and sebfr_deframer.
//
// The req stream carries one received byte per transaction. The rsp stream
// returns exactly one result transaction per byte: a payload buffer write,
// a good-frame report with its length, a check failure, or an all-zero
// record for marker bytes. A payload write that reaches the limit also
// raises overflow and restarts the receiver.
// The csr port writes the payload limit; write it only while no
// transaction is in flight.
// A byte passes through the input register, then the frame state update and
// decode into the result register. Throughput is one byte per cycle while
// the rsp side does not stall, as the frame state updates once per byte.
// When the rsp side stalls, the result register holds its transaction and
// the input register still takes one more byte; req_tready then drops
// until rsp_tready returns.
// Reset clears both registers' valid flags, the frame state, and sets the
// payload limit to 20.
`default_nettype none

module stx_etx_bcc_frame_receiver #(
   parameter int BUF_DEPTH = 32
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [7:0]  req_tdata,   // [7:0] rx_byte
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [23:0] rsp_tdata,   // [4:0] store_index, [12:5] store_data,
                                    // [18:13] frame_length, [23:19] zero
   output logic [3:0]  rsp_tuser,   // [0] store_valid, [1] frame_ok,
                                    // [2] check_fail, [3] overflow
   input  wire         csr_wr_en,
   input  wire  [5:0]  csr_wr_data
);

   logic                  in_valid_ff;
   logic [7:0]            in_byte_ff;
   logic                  out_valid_ff;
   sebfr_pkg::result_type out_ff;
   sebfr_pkg::result_type result;
   logic                  advance;

   assign advance    = !out_valid_ff || rsp_tready;
   assign req_tready = !in_valid_ff || advance;

   sebfr_deframer #(
      .BUF_DEPTH(BUF_DEPTH)
   ) u_deframer (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .step        (in_valid_ff && advance),
      .rx_byte     (in_byte_ff),
      .result      (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_byte_ff <= req_tdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && in_valid_ff) begin
         out_ff <= result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {5'd0, out_ff.frame_length, out_ff.store_data, out_ff.store_index};
   assign rsp_tuser  = {out_ff.overflow, out_ff.check_fail, out_ff.frame_ok,
                        out_ff.store_valid};

`ifndef SYNTHESIS
   a_one_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> $onehot0({out_ff.store_valid, out_ff.frame_ok, out_ff.check_fail}))
      else $error("result carries more than one kind");

   a_overflow_on_store: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && out_ff.overflow) |-> out_ff.store_valid)
      else $error("overflow reported without a payload write");

   a_length_on_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && out_ff.frame_length != 6'd0) |-> out_ff.frame_ok)
      else $error("frame length reported without a good frame");

   a_held_byte_kept: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> (in_valid_ff && $stable(in_byte_ff)))
      else $error("stalled input byte was lost or changed");
`endif

endmodule

`default_nettype wire

>>> rtl/core/sebfr_deframer.sv
// Deframer core: frame state registers, payload limit register and the
// per-byte decode that forms one result record.
// Depends on sebfr_pkg.
`default_nettype none

module sebfr_deframer #(
   parameter int BUF_DEPTH = 32
) (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      csr_wr_en,
   input  wire [5:0]                csr_wr_data,
   input  wire                      step,
   input  wire [7:0]                rx_byte,
   output sebfr_pkg::result_type    result
);

   localparam int CNT_W = $clog2(BUF_DEPTH + 1);
   localparam int LIM_W = (CNT_W > 6) ? CNT_W : 6;
   localparam logic [LIM_W-1:0] DEPTH_LIM = LIM_W'(BUF_DEPTH);

   logic [5:0]       max_payload_ff;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [7:0]       check_ff, check_in;
   logic             started_ff, started_in;
   logic             end_seen_ff, end_seen_in;

   logic [LIM_W-1:0] limit;
   logic [LIM_W-1:0] count_ext;
   logic [LIM_W-1:0] count_inc;

   always_comb begin
      limit = LIM_W'(max_payload_ff);
      if (max_payload_ff == 6'd0 || limit > DEPTH_LIM) begin
         limit = DEPTH_LIM;
      end
      count_ext = LIM_W'(count_ff);
      count_inc = count_ext + LIM_W'(1);
   end

   always_comb begin
      result      = '0;
      count_in    = count_ff;
      check_in    = check_ff;
      started_in  = started_ff;
      end_seen_in = end_seen_ff;
      priority if (rx_byte == sebfr_pkg::MARK_START && !end_seen_ff) begin
         count_in    = '0;
         check_in    = '0;
         started_in  = 1'b1;
         end_seen_in = 1'b0;
      end else if (rx_byte == sebfr_pkg::MARK_END && started_ff && !end_seen_ff) begin
         end_seen_in = 1'b1;
      end else if (end_seen_ff && started_ff) begin
         if (check_ff == rx_byte) begin
            result.frame_ok     = 1'b1;
            result.frame_length = count_ext[5:0];
         end else begin
            result.check_fail = 1'b1;
         end
         count_in    = '0;
         check_in    = '0;
         started_in  = 1'b0;
         end_seen_in = 1'b0;
      end else begin
         result.store_valid = 1'b1;
         result.store_index = count_ext[4:0];
         result.store_data  = rx_byte;
         count_in           = count_inc[CNT_W-1:0];
         check_in           = check_ff ^ rx_byte;
         if (count_inc >= limit) begin
            result.overflow = 1'b1;
            count_in        = '0;
            check_in        = '0;
            started_in      = 1'b0;
            end_seen_in     = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_payload_ff <= sebfr_pkg::MAX_PAYLOAD_RESET;
      end else if (csr_wr_en) begin
         max_payload_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         check_ff    <= '0;
         started_ff  <= 1'b0;
         end_seen_ff <= 1'b0;
      end else if (step) begin
         count_ff    <= count_in;
         check_ff    <= check_in;
         started_ff  <= started_in;
         end_seen_ff <= end_seen_in;
      end
   end

`ifndef SYNTHESIS
   a_end_needs_start: assert property (@(posedge clock) disable iff (reset)
      end_seen_ff |-> started_ff)
      else $error("end marker flag set without a start marker");

   a_count_below_limit: assert property (@(posedge clock) disable iff (reset)
      count_ff < BUF_DEPTH)
      else $error("payload count reached the buffer depth");

   a_restart_after_check: assert property (@(posedge clock) disable iff (reset)
      (step && end_seen_ff) |=> (count_ff == '0 && check_ff == 8'h00 && !started_ff))
      else $error("receiver did not restart after the check byte");
`endif

endmodule

`default_nettype wire
